FILE: hw/rtl/bed_pkg.sv
// shared types and constants for the binary edge detector
package bed_pkg;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // widths fixed by the transaction fields and config registers
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned LINE_W     = 2;

  // 3x3 window with every pixel set
  localparam logic [8:0] FULL_WINDOW = 9'h1FF;

  // per-item control decoded from the stream position
  typedef struct packed {
    logic bot;        // incoming pixel value as it enters the window
    logic top_en;     // row two above lies inside the frame
    logic mid_en;     // row just above lies inside the frame
    logic col_first;  // item sits in column zero
    logic emit;       // item produces a result
    logic last;       // result closes the frame
  } bed_ctl_t;

endpackage

FILE: hw/rtl/bed_ram.sv
// generic single write, single read ram with registered read data
module bed_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/bed_seq.sv
// frame geometry registers and raster position counters
module bed_seq
  import bed_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic                  command,
  input  logic                  pixel,
  output logic [AW-1:0]         rd_addr,
  output bed_ctl_t              ctl
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  logic [WW-1:0] eff_w_r, eff_w_nxt;
  logic [HW-1:0] eff_h_r, eff_h_nxt;
  logic [AW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          col_wrap;
  logic          row_drain_end;

  // clamp incoming geometry into the supported range
  always_comb begin
    eff_w_nxt = eff_w_r;
    eff_h_nxt = eff_h_r;
    if (cfg_we && cfg_index == CFG_FRAME_WIDTH) begin
      if (cfg_data == '0) begin
        eff_w_nxt = WW'(1);
      end else if (32'(cfg_data) > MAX_WIDTH) begin
        eff_w_nxt = WW'(MAX_WIDTH);
      end else begin
        eff_w_nxt = WW'(cfg_data);
      end
    end
    if (cfg_we && cfg_index == CFG_FRAME_HEIGHT) begin
      if (cfg_data == '0) begin
        eff_h_nxt = HW'(1);
      end else if (32'(cfg_data) > MAX_HEIGHT) begin
        eff_h_nxt = HW'(MAX_HEIGHT);
      end else begin
        eff_h_nxt = HW'(cfg_data);
      end
    end
  end

  // position decode for the item at the head of the stream
  assign col_wrap      = (WW'(col_r) + WW'(1)) >= eff_w_r;
  assign row_drain_end = row_r == (RW'(eff_h_r) + RW'(1));

  always_comb begin
    ctl.top_en    = row_r > RW'(1);
    ctl.mid_en    = row_r != '0;
    ctl.bot       = (row_r < RW'(eff_h_r)) && (command == CMD_PIXEL) && pixel;
    ctl.col_first = col_r == '0;
    ctl.emit      = (row_r > RW'(1)) || (row_r == RW'(1) && col_r != '0);
    ctl.last      = (col_r == '0) && row_drain_end;
  end

  // counter advance, restart after the frame end or any config write
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (ctl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(1);
      eff_h_r <= HW'(1);
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      eff_w_r <= eff_w_nxt;
      eff_h_r <= eff_h_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  assign rd_addr = col_r;

endmodule

FILE: hw/rtl/bed_kernel.sv
// line store update, 3x3 window and result register
module bed_kernel
  import bed_pkg::*;
#(
  parameter int unsigned AW = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [AW-1:0]     rd_addr,
  input  bed_ctl_t          ctl,
  output logic              ram_rd_en,
  input  logic [LINE_W-1:0] ram_rd_data,
  output logic              ram_wr_en,
  output logic [AW-1:0]     ram_wr_addr,
  output logic [LINE_W-1:0] ram_wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_edge_res,
  output logic              out_frame_end
);

  logic              s1_valid_r, s1_valid_nxt;
  bed_ctl_t          s1_ctl_r;
  logic [AW-1:0]     s1_addr_r;
  logic              s1_hazard_r;
  logic [LINE_W-1:0] s1_fwd_r;
  logic [8:0]        window_r, window_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_edge_r;
  logic              out_end_r;
  logic              accept;
  logic              commit;
  logic [LINE_W-1:0] stored;
  logic              top, mid;
  logic [2:0]        col;
  logic [8:0]        shifted;
  logic [8:0]        win;
  logic              edge_bit;

  // handshake: the stage moves on when the result register is free or drains
  assign commit   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || commit;
  assign accept   = in_valid && in_ready;

  // read the line store entry as the transaction is taken
  assign ram_rd_en = accept;

  // forward the entry written in the same cycle as the read
  assign stored = s1_hazard_r ? s1_fwd_r : ram_rd_data;
  assign top    = s1_ctl_r.top_en & stored[1];
  assign mid    = s1_ctl_r.mid_en & stored[0];
  assign col    = {s1_ctl_r.bot, mid, top};

  // write back: shift the column down by one row
  assign ram_wr_en   = commit;
  assign ram_wr_addr = s1_addr_r;
  assign ram_wr_data = {mid, s1_ctl_r.bot};

  // window shift, column zero shows the previous row's last pixel
  always_comb begin
    shifted = {3'b000, window_r[8:3]};
    if (s1_ctl_r.col_first) begin
      win        = shifted;
      window_nxt = {col, 6'b000000};
    end else begin
      win        = shifted | {col, 6'b000000};
      window_nxt = win;
    end
    edge_bit = win[4] && (win != FULL_WINDOW);
  end

  // stage one holding register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (commit) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_hazard_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        s1_hazard_r <= commit && (s1_addr_r == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r  <= ctl;
      s1_addr_r <= rd_addr;
      s1_fwd_r  <= {mid, s1_ctl_r.bot};
    end
  end

  // window state, cleared on reset and on any config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (cfg_we) begin
      window_r <= '0;
    end else if (commit) begin
      window_r <= window_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = s1_ctl_r.emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_edge_r <= edge_bit;
      out_end_r  <= s1_ctl_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_edge_res  = out_edge_r;
  assign out_frame_end = out_end_r;

endmodule

FILE: hw/rtl/binary_edge_detect_3x3_core.sv
// top level of the binary 8-neighbour edge detector
//
//  channel | signals                           | direction | transaction
//  --------+-----------------------------------+-----------+-------------------------
//  in      | in_valid/in_ready, command, pixel | input     | one pixel or drain item
//  out     | out_valid/out_ready, edge_res,    | output    | zero or one result
//          | frame_end                         |           |
//  cfg     | cfg_we, cfg_index, cfg_data       | input     | register write
//
// one transaction is taken per cycle while in_ready is high; the line store is read as a
// transaction is taken and written back when it leaves stage one, with forwarding for width one.
// a result is registered as its transaction leaves stage one, and comes
// frame_width+1 transactions later in the stream. reset is synchronous and active low.
// a stalled output holds the window stage; input keeps flowing while the
// result register is free or being taken.
module binary_edge_detect_3x3_core
  import bed_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic                  in_pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_edge_res,
  output logic                  out_frame_end,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic              accept;
  logic [AW-1:0]     rd_addr;
  bed_ctl_t          ctl;
  logic              ram_rd_en;
  logic [LINE_W-1:0] ram_rd_data;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [LINE_W-1:0] ram_wr_data;

  assign accept = in_valid && in_ready;

  // geometry and raster position
  bed_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .command   (in_command),
    .pixel     (in_pixel),
    .rd_addr   (rd_addr),
    .ctl       (ctl)
  );

  // two rows of history, one entry per column
  bed_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rd_data)
  );

  // window and result stage
  bed_kernel #(
    .AW (AW)
  ) u_kernel (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rd_addr       (rd_addr),
    .ctl           (ctl),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_data   (ram_rd_data),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_edge_res  (out_edge_res),
    .out_frame_end (out_frame_end)
  );

endmodule
